// ===== src/mbf_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants for the zero-padded box mean filter.
// No dependencies.
package mbf_pkg;

    localparam int DIM_REG_W  = 11;
    localparam int KS_REG_W   = 4;
    localparam int CFG_DATA_W = 11;
    localparam int CFG_IDX_W  = 1;
    localparam int MEAN_W     = 16;
    localparam int COORD_W    = 10;
    localparam int FRAC_BITS  = 8;

    localparam logic [DIM_REG_W-1:0] DIM_RESET    = 11'd640;
    localparam logic [KS_REG_W-1:0]  KERNEL_RESET = 4'd3;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_DIM   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_SIZE = 1'b1;

endpackage

// ===== src/mean_box_filter_zero_pad_unit.sv =====
`timescale 1ns / 1ps
// Zero-padded k-by-k box mean filter, top level with sequencer.
// Depends on mbf_pkg, mbf_line_mem, mbf_div.

// Pixels of a square image enter in raster order and are kept in a ring of
// MAX_KERNEL+1 line rows. Each item is taken only while the block is idle. A
// pixel is stored at acceptance; then, if the centred window of the next
// output is complete, the window is read from the line store one pixel per
// cycle through one accumulator and the sum times 256 goes through a bit-serial
// divider by k*k. An item with no result goes from S_CHECK back to idle; the
// time that an item with a result takes grows with W, the number of in-image
// window pixels (up to k*k), and is set by the single line-store read port
// and the divider loop. Drain items release outputs after the last
// pixel. A finished result waits in the output register while the next item
// is accepted. Any configuration write restarts the frame.
module mean_box_filter_zero_pad_unit #(
    parameter int MAX_DIM    = 1024,
    parameter int MAX_KERNEL = 15,
    parameter int PIXEL_BITS = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [mbf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mbf_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           opcode,
    input  logic [PIXEL_BITS-1:0]          pixel,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [mbf_pkg::MEAN_W-1:0]     mean_value,
    output logic [mbf_pkg::COORD_W-1:0]    out_row,
    output logic [mbf_pkg::COORD_W-1:0]    out_col,
    output logic                           frame_end
);

    import mbf_pkg::*;

    localparam int STORE_ROWS = MAX_KERNEL + 1;
    localparam int SLOT_W     = $clog2(STORE_ROWS);
    localparam int SLOT_X     = SLOT_W + 1;
    localparam int COL_W      = $clog2(MAX_DIM);
    localparam int POS_W      = $clog2(MAX_DIM + 1);
    localparam int POS_X      = POS_W + 1;
    localparam int KERN_W     = $clog2(MAX_KERNEL + 1);
    localparam int KK_W       = $clog2(MAX_KERNEL * MAX_KERNEL + 1);
    localparam int SUM_W      = PIXEL_BITS + $clog2(MAX_KERNEL * MAX_KERNEL);
    localparam int DVD_W      = SUM_W + FRAC_BITS;
    localparam int ADDR_W     = SLOT_W + COL_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_READ,
        S_SETTLE,
        S_DIV_GO,
        S_DIV_WAIT,
        S_LOAD
    } state_t;

    state_t state_reg, state_next;

    logic [DIM_REG_W-1:0] image_dim_reg, image_dim_next;
    logic [KS_REG_W-1:0]  kernel_size_reg, kernel_size_next;
    logic [POS_W-1:0]     in_row_reg, in_row_next;
    logic [POS_W-1:0]     in_col_reg, in_col_next;
    logic [SLOT_W-1:0]    in_slot_reg, in_slot_next;
    logic [POS_W-1:0]     out_row_reg, out_row_next;
    logic [POS_W-1:0]     out_col_reg, out_col_next;
    logic [SLOT_W-1:0]    out_slot_reg, out_slot_next;
    logic [SLOT_W-1:0]    rd_slot_reg, rd_slot_next;
    logic [COL_W-1:0]     rd_col_reg, rd_col_next;
    logic [KERN_W-1:0]    rows_left_reg, rows_left_next;
    logic [COL_W-1:0]     c0_reg, c0_next;
    logic [COL_W-1:0]     c1_reg, c1_next;
    logic [KK_W-1:0]      kk_reg, kk_next;
    logic [SUM_W-1:0]     sum_reg, sum_next;
    logic                 issued_reg, issued_next;
    logic                 out_valid_reg, out_valid_next;
    logic [MEAN_W-1:0]    mean_reg, mean_next;
    logic [COORD_W-1:0]   orow_reg, orow_next;
    logic [COORD_W-1:0]   ocol_reg, ocol_next;
    logic                 fend_reg, fend_next;

    logic [POS_W-1:0]  dim_eff;
    logic [POS_W-1:0]  dim_m1;
    logic [4:0]        k_raw;
    logic [4:0]        k_sat;
    logic [KERN_W-1:0] k_eff;
    logic [KERN_W-1:0] half_k;

    logic [POS_X-1:0]  row_hi;
    logic [POS_X-1:0]  col_hi;
    logic [POS_W-1:0]  rr;
    logic [POS_W-1:0]  cc;
    logic [POS_W-1:0]  r0;
    logic [POS_W-1:0]  cl0;
    logic [KERN_W-1:0] back;
    logic              release_ok;

    logic              in_fire;
    logic              cfg_fire;
    logic              mem_we;
    logic              mem_re;
    logic [PIXEL_BITS-1:0] mem_rdata;
    logic              div_done;
    logic [DVD_W-1:0]  div_quo;

    // effective image side and kernel size
    always_comb
    begin
        if (image_dim_reg == '0)
        begin
            dim_eff = POS_W'(1);
        end
        else if (int'(image_dim_reg) > MAX_DIM)
        begin
            dim_eff = POS_W'(MAX_DIM);
        end
        else
        begin
            dim_eff = POS_W'(image_dim_reg);
        end
        dim_m1 = dim_eff - 1'b1;

        k_raw = {1'b0, kernel_size_reg} + (kernel_size_reg[0] ? 5'd0 : 5'd1);
        k_sat = (k_raw > 5'(MAX_KERNEL)) ? 5'(MAX_KERNEL) : k_raw;
        if (!k_sat[0])
        begin
            k_sat = k_sat - 5'd1;
        end
        k_eff  = KERN_W'(k_sat);
        half_k = k_eff >> 1;
    end

    // window bounds and release test for the next output
    always_comb
    begin
        row_hi = POS_X'(out_row_reg) + POS_X'(half_k);
        col_hi = POS_X'(out_col_reg) + POS_X'(half_k);
        rr = (row_hi > POS_X'(dim_m1)) ? dim_m1 : POS_W'(row_hi);
        cc = (col_hi > POS_X'(dim_m1)) ? dim_m1 : POS_W'(col_hi);
        r0 = (out_row_reg >= POS_W'(half_k)) ? out_row_reg - POS_W'(half_k) : '0;
        cl0 = (out_col_reg >= POS_W'(half_k)) ? out_col_reg - POS_W'(half_k) : '0;
        back = KERN_W'(out_row_reg - r0);
        release_ok = (in_row_reg > rr) || ((in_row_reg == rr) && (in_col_reg > cc));
    end

    assign cfg_ready = (state_reg == S_IDLE);
    assign in_ready  = (state_reg == S_IDLE) && !cfg_valid;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign in_fire   = in_valid && in_ready;
    assign mem_we    = in_fire && (opcode == OP_PIXEL) && (in_row_reg < dim_eff);
    assign mem_re    = (state_reg == S_READ);

    always_comb
    begin
        state_next       = state_reg;
        image_dim_next   = image_dim_reg;
        kernel_size_next = kernel_size_reg;
        in_row_next      = in_row_reg;
        in_col_next      = in_col_reg;
        in_slot_next     = in_slot_reg;
        out_row_next     = out_row_reg;
        out_col_next     = out_col_reg;
        out_slot_next    = out_slot_reg;
        rd_slot_next     = rd_slot_reg;
        rd_col_next      = rd_col_reg;
        rows_left_next   = rows_left_reg;
        c0_next          = c0_reg;
        c1_next          = c1_reg;
        kk_next          = kk_reg;
        sum_next         = sum_reg;
        issued_next      = (state_reg == S_READ);
        out_valid_next   = out_valid_reg && !out_ready;
        mean_next        = mean_reg;
        orow_next        = orow_reg;
        ocol_next        = ocol_reg;
        fend_next        = fend_reg;

        if (issued_reg)
        begin
            sum_next = sum_reg + SUM_W'(mem_rdata);
        end

        case (state_reg)
            S_IDLE:
            begin
                if (cfg_fire)
                begin
                    if (cfg_index == CFG_IMAGE_DIM)
                    begin
                        image_dim_next = DIM_REG_W'(cfg_data);
                    end
                    else
                    begin
                        kernel_size_next = KS_REG_W'(cfg_data);
                    end
                    in_row_next   = '0;
                    in_col_next   = '0;
                    in_slot_next  = '0;
                    out_row_next  = '0;
                    out_col_next  = '0;
                    out_slot_next = '0;
                end
                else if (in_fire)
                begin
                    if (mem_we)
                    begin
                        if (in_col_reg + 1'b1 >= dim_eff)
                        begin
                            in_col_next  = '0;
                            in_row_next  = in_row_reg + 1'b1;
                            in_slot_next = (in_slot_reg == SLOT_W'(STORE_ROWS - 1)) ?
                                           '0 : in_slot_reg + 1'b1;
                        end
                        else
                        begin
                            in_col_next = in_col_reg + 1'b1;
                        end
                    end
                    state_next = S_CHECK;
                end
            end

            S_CHECK:
            begin
                if (release_ok)
                begin
                    if (out_slot_reg >= SLOT_W'(back))
                    begin
                        rd_slot_next = out_slot_reg - SLOT_W'(back);
                    end
                    else
                    begin
                        rd_slot_next = SLOT_W'(SLOT_X'(out_slot_reg) + SLOT_X'(STORE_ROWS)
                                               - SLOT_X'(back));
                    end
                    rows_left_next = KERN_W'(rr - r0);
                    rd_col_next    = COL_W'(cl0);
                    c0_next        = COL_W'(cl0);
                    c1_next        = COL_W'(cc);
                    kk_next        = KK_W'(k_eff) * KK_W'(k_eff);
                    sum_next       = '0;
                    state_next     = S_READ;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end

            S_READ:
            begin
                if (rd_col_reg == c1_reg)
                begin
                    rd_col_next = c0_reg;
                    if (rows_left_reg == '0)
                    begin
                        state_next = S_SETTLE;
                    end
                    else
                    begin
                        rows_left_next = rows_left_reg - 1'b1;
                        rd_slot_next = (rd_slot_reg == SLOT_W'(STORE_ROWS - 1)) ?
                                       '0 : rd_slot_reg + 1'b1;
                    end
                end
                else
                begin
                    rd_col_next = rd_col_reg + 1'b1;
                end
            end

            S_SETTLE:
            begin
                state_next = S_DIV_GO;
            end

            S_DIV_GO:
            begin
                state_next = S_DIV_WAIT;
            end

            S_DIV_WAIT:
            begin
                if (div_done)
                begin
                    state_next = S_LOAD;
                end
            end

            S_LOAD:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    mean_next      = div_quo[MEAN_W-1:0];
                    orow_next      = COORD_W'(out_row_reg);
                    ocol_next      = COORD_W'(out_col_reg);
                    fend_next      = 1'b0;
                    if (out_col_reg + 1'b1 >= dim_eff)
                    begin
                        out_col_next  = '0;
                        out_row_next  = out_row_reg + 1'b1;
                        out_slot_next = (out_slot_reg == SLOT_W'(STORE_ROWS - 1)) ?
                                        '0 : out_slot_reg + 1'b1;
                        if (out_row_reg + 1'b1 >= dim_eff)
                        begin
                            // frame complete: start over
                            fend_next     = 1'b1;
                            in_row_next   = '0;
                            in_col_next   = '0;
                            in_slot_next  = '0;
                            out_row_next  = '0;
                            out_slot_next = '0;
                        end
                    end
                    else
                    begin
                        out_col_next = out_col_reg + 1'b1;
                    end
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            image_dim_reg   <= DIM_RESET;
            kernel_size_reg <= KERNEL_RESET;
            in_row_reg      <= '0;
            in_col_reg      <= '0;
            in_slot_reg     <= '0;
            out_row_reg     <= '0;
            out_col_reg     <= '0;
            out_slot_reg    <= '0;
            rd_slot_reg     <= '0;
            rd_col_reg      <= '0;
            rows_left_reg   <= '0;
            c0_reg          <= '0;
            c1_reg          <= '0;
            kk_reg          <= '0;
            sum_reg         <= '0;
            issued_reg      <= 1'b0;
            out_valid_reg   <= 1'b0;
            mean_reg        <= '0;
            orow_reg        <= '0;
            ocol_reg        <= '0;
            fend_reg        <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            image_dim_reg   <= image_dim_next;
            kernel_size_reg <= kernel_size_next;
            in_row_reg      <= in_row_next;
            in_col_reg      <= in_col_next;
            in_slot_reg     <= in_slot_next;
            out_row_reg     <= out_row_next;
            out_col_reg     <= out_col_next;
            out_slot_reg    <= out_slot_next;
            rd_slot_reg     <= rd_slot_next;
            rd_col_reg      <= rd_col_next;
            rows_left_reg   <= rows_left_next;
            c0_reg          <= c0_next;
            c1_reg          <= c1_next;
            kk_reg          <= kk_next;
            sum_reg         <= sum_next;
            issued_reg      <= issued_next;
            out_valid_reg   <= out_valid_next;
            mean_reg        <= mean_next;
            orow_reg        <= orow_next;
            ocol_reg        <= ocol_next;
            fend_reg        <= fend_next;
        end
    end

    mbf_line_mem #(
        .ADDR_W (ADDR_W),
        .DATA_W (PIXEL_BITS)
    ) u_line_mem (
        .clk     (clk),
        .we      (mem_we),
        .waddr   ({in_slot_reg, in_col_reg[COL_W-1:0]}),
        .wdata   (pixel),
        .re      (mem_re),
        .raddr   ({rd_slot_reg, rd_col_reg}),
        .rd_data (mem_rdata)
    );

    mbf_div #(
        .DVD_W (DVD_W),
        .DSR_W (KK_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == S_DIV_GO),
        .dividend ({sum_reg, FRAC_BITS'(0)}),
        .divisor  (kk_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign out_valid  = out_valid_reg;
    assign mean_value = mean_reg;
    assign out_row    = orow_reg;
    assign out_col    = ocol_reg;
    assign frame_end  = fend_reg;

`ifndef SYNTHESIS
    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV_WAIT))
        else $error("divider finished outside its wait state");

    a_out_behind_in: assert property (@(posedge clk) disable iff (!rst_n)
        out_row_reg <= in_row_reg)
        else $error("output row ran ahead of input row");

    a_in_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        in_col_reg < dim_eff)
        else $error("input column out of image");

    a_load_only_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOAD && out_valid_reg && !out_ready) |=> $stable(mean_reg))
        else $error("pending item overwritten");
`endif

endmodule

// ===== src/mbf_line_mem.sv =====
`timescale 1ns / 1ps
// Line store: single write port, single registered read port.
// No dependencies.
module mbf_line_mem #(
    parameter int ADDR_W = 14,
    parameter int DATA_W = 8
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [0:(1 << ADDR_W)-1];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rd_data_reg <= mem[raddr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/mbf_div.sv =====
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle.
// No dependencies.
module mbf_div #(
    parameter int DVD_W = 24,
    parameter int DSR_W = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DSR_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DSR_W-1:0] rem_reg;
    logic [DSR_W-1:0] dsr_reg;
    logic [DVD_W-1:0] quo_reg;
    logic [DSR_W:0]   trial;
    logic             fits;

    assign trial = {rem_reg, quo_reg[DVD_W-1]};
    assign fits  = trial >= {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            dsr_reg  <= '0;
            quo_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DVD_W);
                rem_reg  <= '0;
                dsr_reg  <= divisor;
                quo_reg  <= dividend;
            end
            else if (busy_reg)
            begin
                rem_reg <= fits ? DSR_W'(trial - {1'b0, dsr_reg}) : DSR_W'(trial);
                quo_reg <= {quo_reg[DVD_W-2:0], fits};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
